>>> hdl/swmm_pkg.sv
// swmm_pkg: shared types and constants for the sliding window min/max block.
// No dependencies. Used by the deque engine, the top level and the checker.
package swmm_pkg;

  localparam int SAMPLE_W = 32;
  localparam int WIN_W    = 9;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    DQ_IDLE,
    DQ_TAIL,
    DQ_HEAD
  } dq_state_t;

  // Per-sample command from the top level to a deque engine
  typedef struct packed {
    logic start;
    logic clear;
  } dq_ctl_t;

endpackage

>>> hdl/swmm_ram.sv
// swmm_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module swmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/swmm_deque.sv
// swmm_deque: one monotone deque of (value, position) held in a ring buffer RAM.
// Depends on swmm_pkg and swmm_ram. KEEP_GREATER selects max behavior.
module swmm_deque #(
  parameter int MAX_WINDOW   = 256,
  parameter bit KEEP_GREATER = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  swmm_pkg::dq_ctl_t                  ctl,
  input  swmm_pkg::sample_t                  sample,
  input  logic [$clog2(2*MAX_WINDOW)-1:0]    pos,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    win,
  output logic                               fin,
  output swmm_pkg::sample_t                  head_val
);
  import swmm_pkg::*;

  localparam int IW  = $clog2(MAX_WINDOW);
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int PW  = $clog2(2 * MAX_WINDOW);
  localparam int SW  = CW + 1;
  localparam int AW  = PW + 1;
  localparam int EW  = SAMPLE_W + PW;

  dq_state_t         state, state_next;
  logic [IW-1:0]     head, head_next, head_base, head_inc;
  logic [CW-1:0]     count, count_next, cnt_base, cnt_dec;
  sample_t           v;
  logic [PW-1:0]     p;
  logic [CW-1:0]     w;
  sample_t           res_next;
  logic              finish;

  logic              we;
  logic [IW-1:0]     waddr, raddr;
  logic [EW-1:0]     wdata, rdata;
  sample_t           rd_val;
  logic [PW-1:0]     rd_pos;
  logic [AW-1:0]     age;
  logic              drop, expired;

  function automatic logic [IW-1:0] ring(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(off);
    if (s >= SW'(MAX_WINDOW)) begin
      s = s - SW'(MAX_WINDOW);
    end
    return s[IW-1:0];
  endfunction

  swmm_ram #(.WIDTH(EW), .DEPTH(MAX_WINDOW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_val = sample_t'(rdata[SAMPLE_W-1:0]);
  assign rd_pos = rdata[EW-1:SAMPLE_W];

  // Tail compare: ties are dropped so the newest copy survives
  assign drop = KEEP_GREATER ? (rd_val <= v) : (rd_val >= v);

  // Age of the head entry, positions wrap at twice the window bound
  always_comb begin
    if (p >= rd_pos) begin
      age = AW'(p) - AW'(rd_pos);
    end else begin
      age = AW'(p) + AW'(2 * MAX_WINDOW) - AW'(rd_pos);
    end
  end
  assign expired = (age >= AW'(w));

  assign head_base = ctl.clear ? '0 : head;
  assign cnt_base  = ctl.clear ? '0 : count;
  assign cnt_dec   = count - CW'(1);
  assign head_inc  = ring(head, CW'(1));

  always_comb begin
    state_next = state;
    head_next  = head;
    count_next = count;
    raddr      = head;
    we         = 1'b0;
    waddr      = head;
    wdata      = {p, v};
    res_next   = head_val;
    finish     = 1'b0;
    unique case (state)
      DQ_IDLE: begin
        if (ctl.start) begin
          head_next  = head_base;
          count_next = cnt_base;
          if (cnt_base != '0) begin
            raddr      = ring(head_base, cnt_base - CW'(1));
            state_next = DQ_TAIL;
          end else begin
            // empty deque: push straight away, the new sample is the answer
            we         = 1'b1;
            waddr      = head_base;
            wdata      = {pos, sample};
            count_next = CW'(1);
            res_next   = sample;
            finish     = 1'b1;
          end
        end
      end
      DQ_TAIL: begin
        if (drop) begin
          count_next = cnt_dec;
          if (cnt_dec != '0) begin
            raddr = ring(head, cnt_dec - CW'(1));
          end else begin
            we         = 1'b1;
            waddr      = head;
            count_next = CW'(1);
            res_next   = v;
            finish     = 1'b1;
            state_next = DQ_IDLE;
          end
        end else begin
          raddr      = head;
          state_next = DQ_HEAD;
        end
      end
      DQ_HEAD: begin
        if (expired) begin
          head_next  = head_inc;
          count_next = cnt_dec;
          if (cnt_dec != '0) begin
            raddr = head_inc;
          end else begin
            we         = 1'b1;
            waddr      = head_inc;
            count_next = CW'(1);
            res_next   = v;
            finish     = 1'b1;
            state_next = DQ_IDLE;
          end
        end else begin
          res_next = rd_val;
          if (count != CW'(MAX_WINDOW)) begin
            we         = 1'b1;
            waddr      = ring(head, count);
            count_next = count + CW'(1);
          end
          finish     = 1'b1;
          state_next = DQ_IDLE;
        end
      end
      default: begin
        state_next = DQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DQ_IDLE;
      head  <= '0;
      count <= '0;
      fin   <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      fin   <= finish | (fin & ~ctl.start);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      v <= sample;
      p <= pos;
      w <= win;
    end
    head_val <= res_next;
  end

endmodule

>>> hdl/sliding_window_min_max.sv
// Sliding window minimum and maximum over a stream of signed 32-bit samples. Once the
// current sequence holds at least window_len samples, each accepted sample yields one
// result with the min and max of the last window_len samples; start_new restarts the
// sequence. The first sample of a sequence, when both deques start empty, needs no deque
// pass; otherwise each deque drops tail entries no better than the sample, then expired
// head entries, and the slower of the two deques sets when the transaction ends: each
// deque lives in its own RAM and inspects one entry per cycle through its single read
// port. A result waiting in the output register does not block the next sample, but
// that sample's own result holds the input until the output register frees up.
// window_len is written through cfg_we/cfg_wdata; the user must do so only while the
// block is idle, which the block itself does not enforce. 0 acts as 1, values above
// MAX_WINDOW act as MAX_WINDOW. Depends on swmm_pkg, swmm_deque, swmm_ram.
module sliding_window_min_max #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  swmm_pkg::sample_t            sample,
  input  logic                         start_new,
  output logic                         out_valid,
  input  logic                         out_stall,
  output swmm_pkg::sample_t            window_min,
  output swmm_pkg::sample_t            window_max,
  input  logic                         cfg_we,
  input  logic [swmm_pkg::WIN_W-1:0]   cfg_wdata
);
  import swmm_pkg::*;

  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int PW = $clog2(2 * MAX_WINDOW);

  logic [WIN_W-1:0] window_len;
  logic [CW-1:0]    win_eff;
  logic [PW-1:0]    position, pos_base;
  logic [CW-1:0]    filled, filled_base, filled_next;
  logic             busy, emit;
  logic             accept, both_fin, out_free;
  dq_ctl_t          ctl;
  logic             min_fin, max_fin;
  sample_t          min_val, max_val;

  always_comb begin
    if (window_len == '0) begin
      win_eff = CW'(1);
    end else if (32'(window_len) > 32'(MAX_WINDOW)) begin
      win_eff = CW'(MAX_WINDOW);
    end else begin
      win_eff = CW'(window_len);
    end
  end

  assign in_stall    = busy;
  assign accept      = in_valid & ~busy;
  assign ctl.start   = accept;
  assign ctl.clear   = start_new;
  assign pos_base    = start_new ? '0 : position;
  assign filled_base = start_new ? '0 : filled;
  assign filled_next = (filled_base == CW'(MAX_WINDOW)) ? filled_base
                                                        : filled_base + CW'(1);
  assign both_fin    = busy & min_fin & max_fin;
  assign out_free    = ~out_valid | ~out_stall;

  swmm_deque #(.MAX_WINDOW(MAX_WINDOW), .KEEP_GREATER(1'b0)) u_min (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sample   (sample),
    .pos      (pos_base),
    .win      (win_eff),
    .fin      (min_fin),
    .head_val (min_val)
  );

  swmm_deque #(.MAX_WINDOW(MAX_WINDOW), .KEEP_GREATER(1'b1)) u_max (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .sample   (sample),
    .pos      (pos_base),
    .win      (win_eff),
    .fin      (max_fin),
    .head_val (max_val)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WIN_W'(1);
      position   <= '0;
      filled     <= '0;
      busy       <= 1'b0;
      emit       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        window_len <= cfg_wdata;
      end
      if (accept) begin
        busy     <= 1'b1;
        position <= (pos_base == PW'(2 * MAX_WINDOW - 1)) ? '0 : pos_base + PW'(1);
        filled   <= filled_next;
        emit     <= (filled_next >= win_eff);
      end
      // both deques done: free the input, once the output register takes any result
      if (both_fin) begin
        if (!emit) begin
          busy <= 1'b0;
        end else if (out_free) begin
          busy <= 1'b0;
        end
      end
      if (both_fin & emit & out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid & ~out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (both_fin & emit & out_free) begin
      window_min <= min_val;
      window_max <= max_val;
    end
  end

endmodule

>>> hdl/swmm_chk.sv
// swmm_chk: port-level assertions for sliding_window_min_max, attached by bind.
// Depends on swmm_pkg.
module swmm_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input swmm_pkg::sample_t window_min,
  input swmm_pkg::sample_t window_max
);
  import swmm_pkg::*;

  // Nothing left in the output register after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // One sample in flight: an accepted transaction stalls the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after an accepted transaction");

  // A held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(window_min) && $stable(window_max)))
    else $error("stalled result changed");

  // Both fields come from the same window, so window_min never lies above window_max
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_min <= window_max))
    else $error("window_min above window_max");

  // A fresh result only appears while a sample is being worked on
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(in_stall))
    else $error("result without a sample in progress");

endmodule

bind sliding_window_min_max swmm_chk u_swmm_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .window_min (window_min),
  .window_max (window_max)
);

>>> bench/testbench.sv
// Testbench for sliding_window_min_max: random and directed sample streams against an
// in-bench deque tracker, with random gaps on both handshakes and idle-time window writes.
// Depends on swmm_pkg and the sliding_window_min_max RTL.
module testbench;
  import swmm_pkg::*;

  localparam int MAX_WIN = 256;
  localparam int IDX_W = $clog2(MAX_WIN);
  localparam int SIDE_MIN = 0;
  localparam int SIDE_MAX = 1;
  localparam int SETTLE_CYCLES = 400;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int NUM_PHASES = 15;
  localparam int PHASE_WIN [NUM_PHASES] = '{2, 1, 3, 16, 5, 128, 256, 511, 7, 64, 0, 300, 4,
                                            33, 12};
  localparam sample_t S_MIN = 32'sh8000_0000;
  localparam sample_t S_MAX = 32'sh7FFF_FFFF;

  typedef enum int {
    VAL_RANDOM,
    VAL_TIES,
    VAL_RISING,
    VAL_FALLING,
    VAL_EXTREME
  } value_mode_t;

  typedef struct packed {
    sample_t value;
    logic    fresh;
  } stream_item_t;

  typedef struct packed {
    sample_t lo;
    sample_t hi;
  } window_result_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  sample_t          sample = '0;
  logic             start_new = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  sample_t          window_min;
  sample_t          window_max;
  logic             cfg_we = 1'b0;
  logic [WIN_W-1:0] cfg_wdata = '0;

  sliding_window_min_max #(.MAX_WINDOW(MAX_WIN)) uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .start_new  (start_new),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_min (window_min),
    .window_max (window_max),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  stream_item_t   pending_items [$];
  window_result_t expected_extrema [$];
  int             mismatch_count = 0;
  int             cycle_count = 0;

  // Tracker state: one monotone deque per side, ring-indexed like the block
  sample_t          dq_value [2][MAX_WIN];
  logic [WIN_W-1:0] dq_pos [2][MAX_WIN];
  logic [IDX_W-1:0] dq_head [2] = '{'0, '0};
  logic [WIN_W-1:0] dq_count [2] = '{'0, '0};
  logic [WIN_W-1:0] pos_ctr = '0;
  logic [WIN_W-1:0] fill_ctr = '0;
  logic [WIN_W-1:0] win_setting = 9'd1;

  function automatic int clamp_window(logic [WIN_W-1:0] w);
    if (w == '0) return 1;
    if (w > MAX_WIN) return MAX_WIN;
    return int'(w);
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic track_window(input sample_t v, input logic fresh);
    int               span;
    int               side;
    sample_t          tail;
    logic             drop;
    logic [IDX_W-1:0] slot;
    logic [WIN_W-1:0] age;
    window_result_t   res;
    span = clamp_window(win_setting);
    if (fresh) begin
      for (side = SIDE_MIN; side <= SIDE_MAX; side++) begin
        dq_head[side] = '0;
        dq_count[side] = '0;
      end
      pos_ctr = '0;
      fill_ctr = '0;
    end
    for (side = SIDE_MIN; side <= SIDE_MAX; side++) begin
      // tail entries no better than the new sample go first; equal ones too
      while (dq_count[side] != 0) begin
        tail = dq_value[side][IDX_W'(dq_head[side] + dq_count[side] - 1)];
        drop = (side == SIDE_MIN) ? (tail >= v) : (tail <= v);
        if (!drop) break;
        dq_count[side]--;
      end
      while (dq_count[side] != 0) begin
        age = pos_ctr - dq_pos[side][dq_head[side]];
        if (int'(age) < span) break;
        dq_head[side]++;
        dq_count[side]--;
      end
      if (dq_count[side] < MAX_WIN) begin
        slot = IDX_W'(dq_head[side] + dq_count[side]);
        dq_value[side][slot] = v;
        dq_pos[side][slot] = pos_ctr;
        dq_count[side]++;
      end
    end
    pos_ctr++;
    if (fill_ctr < MAX_WIN) fill_ctr++;
    if (int'(fill_ctr) >= span) begin
      res.lo = dq_value[SIDE_MIN][dq_head[SIDE_MIN]];
      res.hi = dq_value[SIDE_MAX][dq_head[SIDE_MAX]];
      expected_extrema.push_back(res);
    end
  endtask

  // Sample driver
  int           gap_left = 0;
  int           send_calm = 0;
  stream_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) track_window(sample, start_new);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          sample <= next_item.value;
          start_new <= next_item.fresh;
          in_valid <= 1'b1;
          if (send_calm > 0) begin
            send_calm--;
            gap_left = 0;
          end else if ($urandom_range(0, 99) < 3) begin
            send_calm = $urandom_range(20, 100);
            gap_left = 0;
          end else if ($urandom_range(0, 99) < 55) begin
            gap_left = 0;
          end else begin
            gap_left = pause_len();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result side back-pressure
  int stall_left = 0;
  int recv_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      recv_calm = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (recv_calm > 0) begin
      recv_calm--;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 2) begin
      recv_calm = $urandom_range(20, 100);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 99) < 70) begin
      out_stall <= 1'b0;
    end else begin
      stall_left = pause_len() - 1;
      out_stall <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk) begin : check_result
    window_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_extrema.size() == 0) begin
        $display("%0t unexpected result: min %0d max %0d", $time, window_min, window_max);
        mismatch_count++;
      end else begin
        want = expected_extrema.pop_front();
        if (window_min !== want.lo) begin
          $display("%0t window_min mismatch: expected %0d actual %0d", $time, want.lo,
                   window_min);
          mismatch_count++;
        end
        if (window_max !== want.hi) begin
          $display("%0t window_max mismatch: expected %0d actual %0d", $time, want.hi,
                   window_max);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_item(input sample_t v, input logic fresh);
    stream_item_t it;
    it.value = v;
    it.fresh = fresh;
    pending_items.push_back(it);
  endtask

  // Sender holds off until every result is back and the block has settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_extrema.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input logic [WIN_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_setting = value;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int          p;
    int          i;
    int          n;
    int          span;
    int          seq_left;
    int          r;
    logic        fresh;
    logic        force_long;
    value_mode_t mode;
    sample_t     ramp;
    sample_t     v;
    seq_left = 0;
    force_long = 1'b0;
    mode = VAL_RANDOM;
    ramp = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // window of one: every sample is its own answer
    set_window(9'd1);
    queue_item(S_MIN, 1'b1);
    queue_item(S_MAX, 1'b0);
    queue_item(32'sd0, 1'b0);
    queue_item(-32'sd1, 1'b0);
    queue_item(32'sd1, 1'b0);
    wait_idle();

    // ties, extremes, and a restart after the window has filled
    set_window(9'd3);
    queue_item(32'sd5, 1'b1);
    queue_item(32'sd5, 1'b0);
    queue_item(32'sd5, 1'b0);
    queue_item(S_MAX, 1'b0);
    queue_item(S_MIN, 1'b0);
    queue_item(-32'sd7, 1'b0);
    queue_item(-32'sd7, 1'b0);
    queue_item(32'sd9, 1'b0);
    queue_item(32'sd2, 1'b1);
    queue_item(32'sd3, 1'b0);
    queue_item(32'sd1, 1'b0);
    wait_idle();

    // zero length behaves as one
    set_window(9'd0);
    queue_item(32'sd42, 1'b0);
    queue_item(-32'sd42, 1'b1);
    queue_item(S_MIN, 1'b0);
    wait_idle();

    // longer window picked up mid-sequence
    set_window(9'd4);
    queue_item(32'sd10, 1'b0);
    queue_item(32'sd11, 1'b0);
    wait_idle();

    for (p = 0; p < NUM_PHASES; p++) begin
      set_window(WIN_W'(PHASE_WIN[p]));
      span = clamp_window(WIN_W'(PHASE_WIN[p]));
      // one sequence spans the large-window phases so the position wraps
      if (PHASE_WIN[p] == 128) begin
        seq_left = 0;
        force_long = 1'b1;
      end
      n = (span >= 100) ? span + $urandom_range(40, 80) : $urandom_range(55, 75);
      for (i = 0; i < n; i++) begin
        if (seq_left == 0) begin
          fresh = 1'b1;
          r = $urandom_range(0, 9);
          if (force_long) seq_left = 900;
          else if (r == 0) seq_left = $urandom_range(1, span);
          else if (r == 1) seq_left = $urandom_range(400, 700);
          else seq_left = span + $urandom_range(0, 2 * span + 8);
          force_long = 1'b0;
          mode = value_mode_t'($urandom_range(0, 4));
          ramp = sample_t'($urandom);
        end else begin
          fresh = (span < 100) && ($urandom_range(0, 49) == 0);
        end
        seq_left--;
        case (mode)
          VAL_TIES: v = sample_t'(int'($urandom_range(0, 8)) - 4);
          VAL_RISING: begin
            ramp = ramp + sample_t'($urandom_range(0, 400));
            v = ramp;
          end
          VAL_FALLING: begin
            ramp = ramp - sample_t'($urandom_range(0, 400));
            v = ramp;
          end
          VAL_EXTREME: begin
            case ($urandom_range(0, 5))
              0: v = S_MIN;
              1: v = S_MAX;
              2: v = S_MIN + 32'sd1;
              3: v = S_MAX - 32'sd1;
              4: v = -32'sd1;
              default: v = 32'sd0;
            endcase
          end
          default: v = sample_t'($urandom);
        endcase
        queue_item(v, fresh);
      end
      wait_idle();
    end

    if (mismatch_count == 0 && expected_extrema.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
